// ----- src/pidw_pkg.sv -----
package pidw_pkg;

	localparam int DataW = 32;
	localparam int LimW  = 31;

	localparam logic [LimW-1:0] LimitReset = 31'd1310720;
	localparam logic [LimW-1:0] RangeReset = 31'd3276800;

	// register indexes of the write port
	typedef enum logic [2:0] {
		REG_GAIN_P    = 3'd0,
		REG_GAIN_I    = 3'd1,
		REG_GAIN_D    = 3'd2,
		REG_SETPOINT  = 3'd3,
		REG_LIMIT     = 3'd4,
		REG_RANGE     = 3'd5,
		REG_ERR_TOL   = 3'd6,
		REG_RATE_TOL  = 3'd7
	} reg_idx_t;

	typedef struct packed {
		logic        [DataW-1:0] gain_p;
		logic        [DataW-1:0] gain_i;
		logic        [DataW-1:0] gain_d;
		logic signed [DataW-1:0] setpoint;
		logic        [LimW-1:0]  integral_limit;
		logic        [LimW-1:0]  integral_range;
		logic        [LimW-1:0]  error_tolerance;
		logic        [LimW-1:0]  rate_tolerance;
	} cfg_t;

	// one queued request: saturated error plus its timestamp and restart bit
	typedef struct packed {
		logic signed [DataW-1:0] err;
		logic        [DataW-1:0] now_ms;
		logic                    restart;
	} qent_t;

endpackage

// ----- src/pidw_front.sv -----
module pidw_front
	import pidw_pkg::*;
(
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic signed [DataW-1:0] setpoint,
	input  logic                    in_valid,
	output logic                    in_ready,
	input  logic signed [DataW-1:0] measurement,
	input  logic        [DataW-1:0] now_ms,
	input  logic                    restart,
	output logic                    q_valid,
	output qent_t                   q_data,
	input  logic                    q_pop
);

	qent_t       mem_q [2];
	logic        wr_ptr_q;
	logic        rd_ptr_q;
	logic [1:0]  count_q;
	logic signed [DataW:0] diff;
	logic signed [DataW-1:0] err;
	logic        push;
	logic        pop;

	// error = setpoint - measurement, saturated to 32 bits
	assign diff = {setpoint[DataW-1], setpoint} - {measurement[DataW-1], measurement};
	always_comb begin
		if (diff[DataW] != diff[DataW-1]) begin
			err = diff[DataW] ? {1'b1, {(DataW-1){1'b0}}} : {1'b0, {(DataW-1){1'b1}}};
		end else begin
			err = diff[DataW-1:0];
		end
	end

	assign in_ready = (count_q != 2'd2);
	assign push     = in_valid & in_ready;
	assign q_valid  = (count_q != 2'd0);
	assign pop      = q_pop & q_valid;
	assign q_data   = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= '{err: err, now_ms: now_ms, restart: restart};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= ~wr_ptr_q;
			if (pop)  rd_ptr_q <= ~rd_ptr_q;
			if (push && !pop)      count_q <= count_q + 2'd1;
			else if (pop && !push) count_q <= count_q - 2'd1;
		end
	end

endmodule

// ----- src/pidw_back.sv -----
module pidw_back
	import pidw_pkg::*;
#(
	parameter int DWELL_MS = 50
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  cfg_t                    cfg,
	input  logic                    q_valid,
	input  qent_t                   q_data,
	output logic                    q_pop,
	output logic                    out_valid,
	input  logic                    out_ready,
	output logic        [DataW-1:0] drive,
	output logic                    arrived
);

	localparam int PW = 49;   // rounded product, signed
	localparam int SW = 51;   // P+I+D sum

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL_P,
		ST_MUL_D,
		ST_INTEG,
		ST_MUL_I,
		ST_RND_I,
		ST_OUT
	} state_t;

	function automatic logic signed [PW-1:0] rnd(input logic [63:0] p, input logic n);
		logic [64:0]   s;
		logic [PW-1:0] r;
		s = {1'b0, p} + 65'h8000;
		r = s[64:16];
		return n ? -r : r;
	endfunction

	state_t                  state_q;
	logic                    first_q;
	logic signed [DataW-1:0] prev_err_q;
	logic signed [DataW-1:0] esum_q;
	logic                    settled_q;
	logic        [DataW-1:0] dwell_start_q;

	logic signed [DataW-1:0] err_q;
	logic        [DataW-1:0] now_q;
	logic signed [DataW:0]   diff_q;
	logic        [DataW-1:0] a_q;
	logic        [DataW-1:0] b_q;
	logic                    neg_q;
	logic        [63:0]      prod_q;
	logic                    prod_neg_q;
	logic signed [PW-1:0]    p_q;
	logic signed [PW-1:0]    d_q;
	logic signed [PW-1:0]    i_q;
	logic                    out_valid_q;
	logic        [DataW-1:0] drive_q;
	logic                    arrived_q;

	logic                    first_now;
	logic signed [DataW-1:0] prev_eff;
	logic signed [DataW:0]   diff_new;
	logic        [DataW-1:0] emag;
	logic        [DataW-1:0] dfmag;
	logic                    on_target;
	logic        [PW-1:0]    pmag;
	logic        [PW-1:0]    dmag;
	logic signed [DataW:0]   acc;
	logic signed [DataW:0]   lim33;
	logic signed [DataW-1:0] clamped;
	logic signed [DataW-1:0] esum_new;
	logic        [DataW-1:0] esmag;
	logic signed [SW-1:0]    total;
	logic signed [DataW-1:0] total_sat;
	logic                    slot_free;
	logic                    rate_ok;
	logic        [DataW-1:0] elapsed;

	assign first_now = first_q | q_data.restart;
	assign prev_eff  = first_now ? q_data.err : prev_err_q;
	assign diff_new  = {q_data.err[DataW-1], q_data.err} - {prev_eff[DataW-1], prev_eff};
	assign dfmag     = diff_q[DataW] ? DataW'(-diff_q) : diff_q[DataW-1:0];

	assign emag      = err_q[DataW-1] ? -err_q : err_q;
	assign on_target = emag <= {1'b0, cfg.error_tolerance};
	assign pmag      = p_q[PW-1] ? -p_q : p_q;
	assign dmag      = d_q[PW-1] ? -d_q : d_q;

	// integrate, clamp to +-limit, then clear when |P| reaches the range, on sign mismatch or on target
	assign acc   = {esum_q[DataW-1], esum_q} + {err_q[DataW-1], err_q};
	assign lim33 = {2'b00, cfg.integral_limit};
	always_comb begin
		if (acc > lim33)       clamped = lim33[DataW-1:0];
		else if (acc < -lim33) clamped = DataW'(-lim33);
		else                   clamped = acc[DataW-1:0];
		if (pmag >= {{(PW-LimW){1'b0}}, cfg.integral_range}) begin
			esum_new = '0;
		end else begin
			esum_new = clamped;
		end
		if (((esum_new > 0) != (err_q > 0)) || ((esum_new < 0) != (err_q < 0)) || on_target) begin
			esum_new = '0;
		end
	end
	assign esmag = esum_new[DataW-1] ? -esum_new : esum_new;

	assign total = SW'(p_q) + SW'(i_q) + SW'(d_q);
	always_comb begin
		if (total > SW'(signed'({1'b0, {(DataW-1){1'b1}}})))
			total_sat = {1'b0, {(DataW-1){1'b1}}};
		else if (total < -(SW'(signed'({1'b0, 1'b1, {(DataW-1){1'b0}}}))))
			total_sat = {1'b1, {(DataW-1){1'b0}}};
		else
			total_sat = total[DataW-1:0];
	end

	assign rate_ok   = dmag <= {{(PW-LimW){1'b0}}, cfg.rate_tolerance};
	assign elapsed   = now_q - dwell_start_q;
	assign slot_free = !out_valid_q || out_ready;
	assign q_pop     = (state_q == ST_IDLE) && q_valid;

	assign out_valid = out_valid_q;
	assign drive     = drive_q;
	assign arrived   = arrived_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			first_q       <= 1'b1;
			prev_err_q    <= '0;
			esum_q        <= '0;
			settled_q     <= 1'b0;
			dwell_start_q <= '0;
			err_q         <= '0;
			now_q         <= '0;
			diff_q        <= '0;
			a_q           <= '0;
			b_q           <= '0;
			neg_q         <= 1'b0;
			prod_q        <= '0;
			prod_neg_q    <= 1'b0;
			p_q           <= '0;
			d_q           <= '0;
			i_q           <= '0;
			out_valid_q   <= 1'b0;
			drive_q       <= '0;
			arrived_q     <= 1'b0;
		end else begin
			// shared multiplier, one registered product per cycle
			prod_q     <= a_q * b_q;
			prod_neg_q <= neg_q;
			// in ST_OUT the output register is handled by the state itself
			if (out_valid_q && out_ready && (state_q != ST_OUT)) out_valid_q <= 1'b0;

			unique case (state_q)
				ST_IDLE: begin
					if (q_valid) begin
						err_q      <= q_data.err;
						now_q      <= q_data.now_ms;
						diff_q     <= diff_new;
						prev_err_q <= q_data.err;
						first_q    <= 1'b0;
						if (first_now) esum_q <= '0;
						a_q        <= cfg.gain_p;
						b_q        <= q_data.err[DataW-1] ? -q_data.err : q_data.err;
						neg_q      <= q_data.err[DataW-1];
						state_q    <= ST_MUL_P;
					end
				end
				ST_MUL_P: begin
					a_q     <= cfg.gain_d;
					b_q     <= dfmag;
					neg_q   <= diff_q[DataW];
					state_q <= ST_MUL_D;
				end
				ST_MUL_D: begin
					p_q     <= rnd(prod_q, prod_neg_q);
					state_q <= ST_INTEG;
				end
				ST_INTEG: begin
					d_q     <= rnd(prod_q, prod_neg_q);
					esum_q  <= esum_new;
					a_q     <= cfg.gain_i;
					b_q     <= esmag;
					neg_q   <= esum_new[DataW-1];
					state_q <= ST_MUL_I;
				end
				ST_MUL_I: begin
					state_q <= ST_RND_I;
				end
				ST_RND_I: begin
					i_q     <= rnd(prod_q, prod_neg_q);
					state_q <= ST_OUT;
				end
				ST_OUT: begin
					if (slot_free) begin
						out_valid_q <= 1'b1;
						drive_q     <= total_sat;
						if (on_target && rate_ok) begin
							if (elapsed >= DataW'(DWELL_MS)) begin
								settled_q <= 1'b1;
								arrived_q <= 1'b1;
							end else begin
								arrived_q <= settled_q;
							end
						end else begin
							dwell_start_q <= now_q;
							settled_q     <= 1'b0;
							arrived_q     <= 1'b0;
						end
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

// ----- src/pid_with_windup_and_arrival.sv -----
// Channel   Dir  Handshake                      Payload
// s_axis    in   s_axis_tvalid/s_axis_tready    tdata: measurement, now_ms; tuser: restart
// m_axis    out  m_axis_tvalid/m_axis_tready    tdata: drive; tuser: arrived
// cfg       in   cfg_we (no wait)               cfg_addr selects register, cfg_wdata
//
// In the back end each request makes three passes through one shared
// 32x32 multiplier (P, D, I) with rounding and integral update between them.
// The front end computes the saturated error and holds up to 2 requests, so
// input is taken while the back end works or the output waits, until the queue is full.
// arst_n clears the queue, the controller state and the output register; the
// first request after reset counts as a restart.
// A stalled m_axis only holds the back end in its final step; the queue fills.
module pid_with_windup_and_arrival
	import pidw_pkg::*;
#(
	parameter int DWELL_MS = 50
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [63:0] s_axis_tdata,   // [31:0] measurement, [63:32] now_ms
	input  logic        s_axis_tuser,   // [0] restart
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [31:0] m_axis_tdata,   // [31:0] drive
	output logic        m_axis_tuser,   // [0] arrived
	input  logic        cfg_we,
	input  logic [2:0]  cfg_addr,
	input  logic [31:0] cfg_wdata
);

	cfg_t  cfg_q;
	logic  q_valid;
	qent_t q_data;
	logic  q_pop;

	// configuration registers; the narrow ones drop the top bit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.gain_p          <= '0;
			cfg_q.gain_i          <= '0;
			cfg_q.gain_d          <= '0;
			cfg_q.setpoint        <= '0;
			cfg_q.integral_limit  <= LimitReset;
			cfg_q.integral_range  <= RangeReset;
			cfg_q.error_tolerance <= '0;
			cfg_q.rate_tolerance  <= '0;
		end else if (cfg_we) begin
			unique case (reg_idx_t'(cfg_addr))
				REG_GAIN_P:   cfg_q.gain_p          <= cfg_wdata;
				REG_GAIN_I:   cfg_q.gain_i          <= cfg_wdata;
				REG_GAIN_D:   cfg_q.gain_d          <= cfg_wdata;
				REG_SETPOINT: cfg_q.setpoint        <= cfg_wdata;
				REG_LIMIT:    cfg_q.integral_limit  <= cfg_wdata[LimW-1:0];
				REG_RANGE:    cfg_q.integral_range  <= cfg_wdata[LimW-1:0];
				REG_ERR_TOL:  cfg_q.error_tolerance <= cfg_wdata[LimW-1:0];
				REG_RATE_TOL: cfg_q.rate_tolerance  <= cfg_wdata[LimW-1:0];
				default: ;
			endcase
		end
	end

	// front end: error computation and request queue
	pidw_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.setpoint    (cfg_q.setpoint),
		.in_valid    (s_axis_tvalid),
		.in_ready    (s_axis_tready),
		.measurement (s_axis_tdata[31:0]),
		.now_ms      (s_axis_tdata[63:32]),
		.restart     (s_axis_tuser),
		.q_valid     (q_valid),
		.q_data      (q_data),
		.q_pop       (q_pop)
	);

	// back end: P/D/I sequencing, integral clamp, arrival timer, output reg
	pidw_back #(
		.DWELL_MS (DWELL_MS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.q_valid   (q_valid),
		.q_data    (q_data),
		.q_pop     (q_pop),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.drive     (m_axis_tdata),
		.arrived   (m_axis_tuser)
	);

endmodule
